/* rtl/wall_follow_pid_steering_top_assert.svh */
// Assertion macros for the checker file of the steering block.
`ifndef WALL_FOLLOW_PID_STEERING_TOP_ASSERT_SVH
`define WALL_FOLLOW_PID_STEERING_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is low.
`define WFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define WFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define WFP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wfp_pkg.sv */
package wfp_pkg;

    localparam int DIST_W   = 10;
    localparam int TIME_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 8;
    localparam int BOOST_W  = 16;
    localparam int ERR_W    = DIST_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int SUM_W    = 21;
    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + SUM_W;
    localparam int PROD_D_W = GAIN_W + DIFF_W;
    localparam int PID_W    = PROD_I_W + 1;
    localparam int SCALED_W = PID_W + 4;
    localparam int DRIVE_W  = SCALED_W + 2;
    localparam int BASE_W   = LIM_W + 10;
    localparam int SPEED_W  = LIM_W + 1;

    // Division by 1280 once the value is known to be below 256*1280:
    // drop 8 bits, then divide by 5 as a multiply by 1639/8192.
    localparam int THR_W         = 19;
    localparam int QUOT_W        = 11;
    localparam int RECIP_SHIFT   = 13;
    localparam int RECIP_PROD_W  = 22;
    localparam logic [QUOT_W-1:0] RECIP_FIVE = 11'd1639;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 24;

    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_SPEED    = 3'd3;
    localparam logic [2:0] REG_OBSTACLE = 3'd4;
    localparam logic [2:0] REG_BOOST    = 3'd5;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_P   = 16'sd256;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I   = 16'sd0;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D   = 16'sd0;
    localparam logic [LIM_W-1:0]         RST_SPEED    = 8'd255;
    localparam logic [DIST_W-1:0]        RST_OBSTACLE = 10'd9;
    localparam logic [BOOST_W-1:0]       RST_BOOST    = 16'd1000;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 21'sh0FFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 21'sh100000;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] scaled;
        logic [LIM_W-1:0]          limit;
    } t_drive_req;

endpackage

/* rtl/wall_follow_pid_steering_top.sv */
// Each beat moves through the stage A, B, C and D registers; D drives the output.
// Throughput: one beat per cycle unless stalled, set by the four-register pipeline
// whose integral, previous error and boost state update in the first stage alone.
// Reset (synchronous, active low): empties the pipeline, clears the integral,
// previous error and boost window, and loads the register defaults.
module wall_follow_pid_steering_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sensor beats. Bits from 0: left_dist[9:0], middle_dist[19:10],
    // right_dist[29:20], now_ms[61:30], zero padding [63:62].
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [wfp_pkg::IN_W-1:0]      s_axis_tdata,
    // Drive beats. Bits from 0: left_speed[8:0], right_speed[17:9],
    // boosting[18], zero padding [23:19].
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wfp_pkg::OUT_W-1:0]     m_axis_tdata,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wfp_pkg::ADDR_W-1:0]    paddr,
    input  logic [wfp_pkg::DATA_W-1:0]    pwdata,
    output logic [wfp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import wfp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; software is
    // to write them only while no beat is in flight; the block does not check.
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [LIM_W-1:0]         r_speed_max;
    logic [DIST_W-1:0]        r_obstacle_cm;
    logic [BOOST_W-1:0]       r_boost_ms;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= RST_GAIN_P;
            r_gain_i      <= RST_GAIN_I;
            r_gain_d      <= RST_GAIN_D;
            r_speed_max   <= RST_SPEED;
            r_obstacle_cm <= RST_OBSTACLE;
            r_boost_ms    <= RST_BOOST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GAIN_P:   r_gain_p      <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_I:   r_gain_i      <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_D:   r_gain_d      <= $signed(pwdata[GAIN_W-1:0]);
                REG_SPEED:    r_speed_max   <= pwdata[LIM_W-1:0];
                REG_OBSTACLE: r_obstacle_cm <= pwdata[DIST_W-1:0];
                REG_BOOST:    r_boost_ms    <= pwdata[BOOST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GAIN_P:   prdata = {16'b0, r_gain_p};
            REG_GAIN_I:   prdata = {16'b0, r_gain_i};
            REG_GAIN_D:   prdata = {16'b0, r_gain_d};
            REG_SPEED:    prdata = {24'b0, r_speed_max};
            REG_OBSTACLE: prdata = {22'b0, r_obstacle_cm};
            REG_BOOST:    prdata = {16'b0, r_boost_ms};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage accepts when it is empty or when
    // the stage after it is moving, so bubbles close up and a finished
    // result can wait at the output while new samples keep coming in.
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic ready_a, ready_b, ready_c, ready_d;
    logic a_fire;

    assign ready_d = !r_d_valid || m_axis_tready;
    assign ready_c = !r_c_valid || ready_d;
    assign ready_b = !r_b_valid || ready_c;
    assign ready_a = !r_a_valid || ready_b;
    assign a_fire  = r_a_valid && ready_b;

    assign s_axis_tready = ready_a;
    assign m_axis_tvalid = r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (ready_a) r_a_valid <= s_axis_tvalid;
            if (ready_b) r_b_valid <= r_a_valid;
            if (ready_c) r_c_valid <= r_b_valid;
            if (ready_d) r_d_valid <= r_c_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] r_a_left, r_a_mid, r_a_right;
    logic [TIME_W-1:0] r_a_now;

    always_ff @(posedge i_clk) begin
        if (ready_a && s_axis_tvalid) begin
            r_a_left  <= s_axis_tdata[0 +: DIST_W];
            r_a_mid   <= s_axis_tdata[DIST_W +: DIST_W];
            r_a_right <= s_axis_tdata[2*DIST_W +: DIST_W];
            r_a_now   <= s_axis_tdata[3*DIST_W +: TIME_W];
        end
    end

    // ------------------------------------------------------------------
    // Controller state and the A to B step: error, the three products and
    // the boost window. The state moves once per sample, as it leaves A.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  r_error_sum, n_error_sum;
    logic signed [ERR_W-1:0]  r_last_error;
    logic                     r_boost_on, n_boost_on;
    logic [TIME_W-1:0]        r_boost_start, n_boost_start;

    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] err_diff;
    logic signed [SUM_W:0]    sum_wide;
    logic                     boost_open;
    logic                     boost_armed;
    logic [TIME_W-1:0]        elapsed;

    assign err      = $signed({1'b0, r_a_right}) - $signed({1'b0, r_a_left});
    assign err_diff = $signed({err[ERR_W-1], err})
                    - $signed({r_last_error[ERR_W-1], r_last_error});

    // The integral clamps to its own 21-bit range, so overflow shows as the
    // two top bits of the widened sum disagreeing.
    assign sum_wide = $signed({r_error_sum[SUM_W-1], r_error_sum}) + (SUM_W+1)'(err);
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            n_error_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_error_sum = sum_wide[SUM_W-1:0];
        end
    end

    // A close middle reading opens the window first; the end test then runs
    // on the updated start time, so a zero-length window never shows.
    assign boost_open    = (r_a_mid < r_obstacle_cm) && !r_boost_on;
    assign n_boost_start = boost_open ? r_a_now : r_boost_start;
    assign boost_armed   = r_boost_on || boost_open;
    assign elapsed       = r_a_now - n_boost_start;
    assign n_boost_on    = boost_armed && (elapsed < {16'b0, r_boost_ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum   <= '0;
            r_last_error  <= '0;
            r_boost_on    <= 1'b0;
            r_boost_start <= '0;
        end else if (a_fire) begin
            r_error_sum   <= n_error_sum;
            r_last_error  <= err;
            r_boost_on    <= n_boost_on;
            r_boost_start <= n_boost_start;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: the three gain products, each straight off one multiplier.
    // ------------------------------------------------------------------
    logic signed [PROD_P_W-1:0] r_b_p;
    logic signed [PROD_I_W-1:0] r_b_i;
    logic signed [PROD_D_W-1:0] r_b_d;
    logic                       r_b_boost;

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_p     <= PROD_P_W'(r_gain_p) * PROD_P_W'(err);
            r_b_i     <= PROD_I_W'(r_gain_i) * PROD_I_W'(r_error_sum);
            r_b_d     <= PROD_D_W'(r_gain_d) * PROD_D_W'(err_diff);
            r_b_boost <= n_boost_on;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: PID sum, doubled inside the boost window, times five. The
    // 0.6 base factor and the later division by 1280 keep this exact.
    // ------------------------------------------------------------------
    logic signed [PID_W-1:0]    pid;
    logic signed [SCALED_W-1:0] pid_ext;
    logic signed [SCALED_W-1:0] pid_eff;
    logic signed [SCALED_W-1:0] r_c_pid5;
    logic                       r_c_boost;

    assign pid     = PID_W'(r_b_p) + PID_W'(r_b_i) + PID_W'(r_b_d);
    assign pid_ext = SCALED_W'(pid);
    assign pid_eff = r_b_boost ? (pid_ext <<< 1) : pid_ext;

    always_ff @(posedge i_clk) begin
        if (r_b_valid && ready_c) begin
            r_c_pid5  <= (pid_eff <<< 2) + pid_eff;
            r_c_boost <= r_b_boost;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: base plus and minus the scaled PID, divided by 1280 and
    // saturated to the speed limit, into the output register.
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]            base;
    logic signed [DRIVE_W-1:0]    base_ext;
    logic signed [DRIVE_W-1:0]    pid5_ext;
    t_drive_req                   req_left, req_right;
    logic signed [SPEED_W-1:0]    speed_left, speed_right;
    logic signed [SPEED_W-1:0]    r_d_left, r_d_right;
    logic                         r_d_boost;

    // 768 = 512 + 256, so base is 0.6 of the limit in units of 1/1280.
    assign base     = {1'b0, r_speed_max, 9'b0} + {2'b0, r_speed_max, 8'b0};
    assign base_ext = $signed({{(DRIVE_W-BASE_W){1'b0}}, base});
    assign pid5_ext = DRIVE_W'(r_c_pid5);

    assign req_left.scaled  = base_ext + pid5_ext;
    assign req_left.limit   = r_speed_max;
    assign req_right.scaled = base_ext - pid5_ext;
    assign req_right.limit  = r_speed_max;

    wfp_drive u_drive_left (
        .i_req   (req_left),
        .o_speed (speed_left)
    );

    wfp_drive u_drive_right (
        .i_req   (req_right),
        .o_speed (speed_right)
    );

    always_ff @(posedge i_clk) begin
        if (r_c_valid && ready_d) begin
            r_d_left  <= speed_left;
            r_d_right <= speed_right;
            r_d_boost <= r_c_boost;
        end
    end

    assign m_axis_tdata = {5'b0, r_d_boost, r_d_right, r_d_left};

endmodule

/* rtl/wfp_drive.sv */
module wfp_drive (
    input  wfp_pkg::t_drive_req                 i_req,
    output logic signed [wfp_pkg::SPEED_W-1:0]  o_speed
);
    import wfp_pkg::*;

    logic                     neg;
    logic [DRIVE_W-1:0]       mag;
    logic [LIM_W:0]           lim_inc;
    logic [THR_W-1:0]         thr;
    logic                     sat;
    logic [QUOT_W-1:0]        quot;
    logic [RECIP_PROD_W-1:0]  prod;
    logic [LIM_W-1:0]         res;

    // The scaled value is in units of 1/1280 of a speed step; truncation
    // toward zero is done on the magnitude and the sign put back after.
    assign neg = i_req.scaled[DRIVE_W-1];
    assign mag = neg ? DRIVE_W'(-i_req.scaled) : DRIVE_W'(i_req.scaled);

    // Anything at or above (limit+1)*1280 saturates; 1280 = 1024 + 256.
    assign lim_inc = {1'b0, i_req.limit} + {{LIM_W{1'b0}}, 1'b1};
    assign thr     = {lim_inc, 10'b0} + {2'b0, lim_inc, 8'b0};
    assign sat     = mag >= DRIVE_W'(thr);

    assign quot = mag[8 +: QUOT_W];
    assign prod = RECIP_PROD_W'(quot) * RECIP_PROD_W'(RECIP_FIVE);
    assign res  = sat ? i_req.limit : prod[RECIP_SHIFT +: LIM_W];

    assign o_speed = neg ? -$signed({1'b0, res}) : $signed({1'b0, res});

endmodule

/* rtl/wfp_checker.sv */
`include "wall_follow_pid_steering_top_assert.svh"

module wfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A result that is not taken stays on the port unchanged.
    `WFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

    // Reset empties the pipeline, so nothing is offered right after it.
    `WFP_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

    // Drives are saturated to at most 255 in size, so -256 never appears.
    `WFP_ASSERT_NOW(a_speed_range, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[8:0] != 9'h100) && (m_axis_tdata[17:9] != 9'h100), "drive outside the speed range")

    // The padding above the boost flag is always zero.
    `WFP_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[23:19] == 5'b0, "nonzero padding in output beat")

endmodule

bind wall_follow_pid_steering_top wfp_checker u_wfp_checker (.*);

/* tb/sv/tb_wall_follow_pid_steering_top.sv */
module tb_wall_follow_pid_steering_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wfp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    // Extra wait after the drive queue empties; the slack is generous.
    localparam int DRAIN_SLACK  = 8;
    localparam int CYCLE_LIMIT  = 600000;

    localparam longint INTEG_HI = 64'sd1048575;
    localparam longint INTEG_LO = -64'sd1048576;

    // Receiver stall patterns.
    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} t_rx_mode;

    // Bit layout matches m_axis_tdata[18:0].
    typedef struct packed {
        logic       boost;
        logic [8:0] right;
        logic [8:0] left;
    } t_drive;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // Bits from 0: left_dist[9:0], middle_dist[19:10], right_dist[29:20], now_ms[61:30].
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // Bits from 0: left_speed[8:0], right_speed[17:9], boosting[18].
    logic [OUT_W-1:0]  m_axis_tdata;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    wall_follow_pid_steering_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Steering predictor: its own copy of the registers and the
    // controller state, updated once per accepted sensor beat.
    // ------------------------------------------------------------------
    int          gain_kp;
    int          gain_ki;
    int          gain_kd;
    logic [7:0]  speed_lim;
    logic [9:0]  obstacle_lvl;
    logic [15:0] boost_len;

    longint      integ;
    int          prev_err;
    bit          boost_active;
    logic [31:0] boost_stamp;

    t_drive      pending_drives[$];

    int mismatch_count = 0;
    int sensor_beats   = 0;
    int drives_checked = 0;
    int reg_writes     = 0;
    int boosts_opened  = 0;
    int clamp_hits     = 0;
    int cycle_count    = 0;

    // Idling controls for the sender task and the receiver process.
    t_rx_mode stall_mode    = RX_RANDOM;
    bit       sender_steady = 1'b0;
    int       burst_left    = 0;
    int       stall_phase   = 0;
    int       stall_hold    = 0;

    // Running millisecond stamp for the generated samples.
    logic [31:0] ms_clock = '0;

    t_drive seen_drive;
    t_drive want_drive;

    function automatic void reset_steering_model();
        gain_kp      = int'(RST_GAIN_P);
        gain_ki      = int'(RST_GAIN_I);
        gain_kd      = int'(RST_GAIN_D);
        speed_lim    = RST_SPEED;
        obstacle_lvl = RST_OBSTACLE;
        boost_len    = RST_BOOST;
        integ        = 0;
        prev_err     = 0;
        boost_active = 1'b0;
        boost_stamp  = '0;
    endfunction

    function automatic void set_model_register(logic [2:0] idx, logic [15:0] value);
        case (idx)
            REG_GAIN_P:   gain_kp = int'($signed(value));
            REG_GAIN_I:   gain_ki = int'($signed(value));
            REG_GAIN_D:   gain_kd = int'($signed(value));
            REG_SPEED:    speed_lim = value[7:0];
            REG_OBSTACLE: obstacle_lvl = value[9:0];
            REG_BOOST:    boost_len = value;
            default: ;
        endcase
    endfunction

    function automatic longint clamp_drive(longint scaled, longint lim);
        longint v;
        v = scaled / 1280;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic t_drive predict_drive(logic [9:0] left, logic [9:0] mid,
                                             logic [9:0] right, logic [31:0] stamp);
        int          err;
        longint      pid;
        longint      base;
        logic [31:0] elapsed;
        t_drive      d;
        // The window opens before the end test runs, so a zero window closes at once.
        if (mid < obstacle_lvl && !boost_active) begin
            boost_active = 1'b1;
            boost_stamp  = stamp;
            boosts_opened++;
        end
        elapsed = stamp - boost_stamp;
        if (boost_active && elapsed >= {16'd0, boost_len}) boost_active = 1'b0;

        err = int'(right) - int'(left);
        pid = longint'(gain_kp) * err + longint'(gain_ki) * integ
            + longint'(gain_kd) * (err - prev_err);

        integ += err;
        if (integ > INTEG_HI) begin
            integ = INTEG_HI;
            clamp_hits++;
        end
        if (integ < INTEG_LO) begin
            integ = INTEG_LO;
            clamp_hits++;
        end
        prev_err = err;

        if (boost_active) pid *= 2;

        // Drives are worked out in units of 1/1280, base being 0.6 of the limit.
        base    = longint'(speed_lim) * 768;
        d.left  = 9'(clamp_drive(base + 5 * pid, longint'(speed_lim)));
        d.right = 9'(clamp_drive(base - 5 * pid, longint'(speed_lim)));
        d.boost = boost_active;
        return d;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker. Outputs are sampled at the rising edge, before the
    // nonblocking updates of that edge land, so ordering cannot matter.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_drives.size() == 0) begin
                flag_mismatch("drive beat with nothing expected", int'(m_axis_tdata), 0);
            end else begin
                want_drive = pending_drives.pop_front();
                seen_drive = m_axis_tdata[18:0];
                drives_checked++;
                if (seen_drive.left !== want_drive.left)
                    flag_mismatch("left_speed", $signed(seen_drive.left),
                                  $signed(want_drive.left));
                if (seen_drive.right !== want_drive.right)
                    flag_mismatch("right_speed", $signed(seen_drive.right),
                                  $signed(want_drive.right));
                if (seen_drive.boost !== want_drive.boost)
                    flag_mismatch("boosting", seen_drive.boost, want_drive.boost);
            end
        end
    end

    // The receiver stalls on a pattern picked per test, independent of the sender.
    always @(posedge i_clk) begin
        case (stall_mode)
            RX_OPEN: begin
                m_axis_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            end
            RX_PERIODIC: begin
                stall_phase   <= (stall_phase >= 6) ? 0 : stall_phase + 1;
                m_axis_tready <= (stall_phase >= 3);
            end
            RX_LONG: begin
                if (stall_hold == 0) begin
                    m_axis_tready <= ~m_axis_tready;
                    stall_hold    <= $urandom_range(0, 20);
                end else begin
                    stall_hold <= stall_hold - 1;
                end
            end
            default: m_axis_tready <= 1'b1;
        endcase
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Sends one sensor beat. Outside steady mode the sender runs in bursts of
    // random length with random gaps, so gaps land on every pipeline phase.
    // The expectation is queued by this same process at the accepting edge.
    task automatic send_sample(input logic [9:0] left, input logic [9:0] mid,
                               input logic [9:0] right, input logic [31:0] stamp);
        int gap;
        if (!sender_steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, stamp, right, mid, left};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_drives.push_back(predict_drive(left, mid, right, stamp));
        sensor_beats++;
    endtask

    // Stops sending and waits until every queued drive beat has come back,
    // then lets the pipeline settle. Register writes only follow this.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Register write with a setup and an access phase; the unused upper data bits carry noise.
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        set_model_register(idx, value);
        reg_writes++;
    endtask

    // Reads every register back and compares the implemented bits.
    task automatic check_all_registers();
        logic [31:0] got;
        logic [31:0] want;
        logic [31:0] mask;
        for (int k = REG_GAIN_P; k <= REG_BOOST; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(k), 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            got     = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            case (3'(k))
                REG_GAIN_P:   begin want = 32'(gain_kp);      mask = 32'h0000_FFFF; end
                REG_GAIN_I:   begin want = 32'(gain_ki);      mask = 32'h0000_FFFF; end
                REG_GAIN_D:   begin want = 32'(gain_kd);      mask = 32'h0000_FFFF; end
                REG_SPEED:    begin want = 32'(speed_lim);    mask = 32'h0000_00FF; end
                REG_OBSTACLE: begin want = 32'(obstacle_lvl); mask = 32'h0000_03FF; end
                default:      begin want = 32'(boost_len);    mask = 32'h0000_FFFF; end
            endcase
            if ((got & mask) !== (want & mask))
                flag_mismatch($sformatf("register %0d read-back", k),
                              int'(got & mask), int'(want & mask));
        end
    endtask

    task automatic shuffle_idling();
        stall_mode    = t_rx_mode'($urandom_range(0, 3));
        sender_steady = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h0100;
            4:       return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    // A long run of full-scale error in one direction drives the integral
    // into its clamp; the middle readings and time stamps stay random.
    task automatic drive_error_run(input int count, input bit toward_right);
        for (int n = 0; n < count; n++) begin
            ms_clock += $urandom_range(0, 50);
            if (toward_right)
                send_sample(10'd0, 10'($urandom), 10'd1023, ms_clock);
            else
                send_sample(10'd1023, 10'($urandom), 10'd0, ms_clock);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Defaults after reset, then every register written and read back.
    task automatic test_register_readback();
        check_all_registers();
        write_register(REG_GAIN_P, 16'($urandom));
        write_register(REG_GAIN_I, 16'($urandom));
        write_register(REG_GAIN_D, 16'($urandom));
        write_register(REG_SPEED, 16'($urandom));
        write_register(REG_OBSTACLE, 16'($urandom));
        write_register(REG_BOOST, 16'($urandom));
        check_all_registers();
        write_register(REG_GAIN_P, RST_GAIN_P);
        write_register(REG_GAIN_I, RST_GAIN_I);
        write_register(REG_GAIN_D, RST_GAIN_D);
        write_register(REG_SPEED, 16'(RST_SPEED));
        write_register(REG_OBSTACLE, 16'(RST_OBSTACLE));
        write_register(REG_BOOST, RST_BOOST);
    endtask

    // Default settings: full-scale errors both ways, zero error, and a boost
    // window that opens, holds at 999 ms and closes exactly at its length.
    task automatic test_default_steering();
        shuffle_idling();
        send_sample(10'd0, 10'd1023, 10'd1023, 32'd0);
        send_sample(10'd1023, 10'd1023, 10'd0, 32'd10);
        send_sample(10'd512, 10'd512, 10'd512, 32'd20);
        send_sample(10'd500, 10'd0, 10'd510, 32'd100);
        send_sample(10'd510, 10'd8, 10'd500, 32'd1099);
        // Still below the threshold here, but the window closes first.
        send_sample(10'd500, 10'd5, 10'd520, 32'd1100);
        send_sample(10'd500, 10'd5, 10'd520, 32'd1101);
        // A reading equal to the threshold starts nothing.
        send_sample(10'd0, 10'd9, 10'd0, 32'd1200);
        wait_drained();
    endtask

    // Zero-length window, a window that spans the wrap of the time stamp,
    // and the threshold at both ends of its range.
    task automatic test_boost_window();
        shuffle_idling();
        write_register(REG_OBSTACLE, 16'd1023);
        write_register(REG_BOOST, 16'd0);
        send_sample(10'd300, 10'd0, 10'd310, 32'd1300);
        send_sample(10'd300, 10'd0, 10'd310, 32'd1301);
        wait_drained();
        write_register(REG_BOOST, 16'hFFFF);
        send_sample(10'd100, 10'd1022, 10'd90, 32'hFFFF_FFF0);
        send_sample(10'd100, 10'd1023, 10'd90, 32'h0000_FFDF);
        send_sample(10'd100, 10'd1023, 10'd90, 32'h0000_FFEF);
        send_sample(10'd100, 10'd1023, 10'd90, 32'h0000_FFF0);
        wait_drained();
        write_register(REG_OBSTACLE, 16'd0);
        send_sample(10'd100, 10'd0, 10'd90, 32'd5);
        wait_drained();
    endtask

    // Zero and tiny speed limits, and the gains at their extremes.
    task automatic test_limits_and_gains();
        shuffle_idling();
        write_register(REG_SPEED, 16'd0);
        send_sample(10'd0, 10'd500, 10'd1023, 32'd10);
        send_sample(10'd1023, 10'd500, 10'd0, 32'd20);
        wait_drained();
        write_register(REG_SPEED, 16'd1);
        write_register(REG_GAIN_P, 16'h8000);
        write_register(REG_GAIN_I, 16'h7FFF);
        write_register(REG_GAIN_D, 16'h7FFF);
        send_sample(10'd0, 10'd700, 10'd1023, 32'd30);
        send_sample(10'd1023, 10'd700, 10'd0, 32'd40);
        send_sample(10'd400, 10'd700, 10'd400, 32'd50);
        wait_drained();
        write_register(REG_SPEED, 16'd255);
        write_register(REG_GAIN_P, 16'h7FFF);
        write_register(REG_GAIN_I, 16'h8000);
        write_register(REG_GAIN_D, 16'h8000);
        send_sample(10'd1023, 10'd700, 10'd0, 32'd60);
        send_sample(10'd0, 10'd700, 10'd1023, 32'd70);
        wait_drained();
        // Small gains keep the drives inside the limit.
        write_register(REG_GAIN_P, 16'd3);
        write_register(REG_GAIN_I, 16'd0);
        write_register(REG_GAIN_D, 16'hFFFB);
        send_sample(10'd200, 10'd700, 10'd260, 32'd80);
        send_sample(10'd260, 10'd700, 10'd200, 32'd90);
        wait_drained();
    endtask

    // With only a unit integral gain the integral is pushed into its upper
    // clamp. A proportional gain of -1025 then cancels the clamped integral
    // against a full-scale error exactly, so the drives sit at the base and
    // any error in the clamped value shows at once.
    task automatic test_integral_saturation();
        shuffle_idling();
        write_register(REG_GAIN_P, 16'd0);
        write_register(REG_GAIN_I, 16'd1);
        write_register(REG_GAIN_D, 16'd0);
        write_register(REG_SPEED, 16'd255);
        write_register(REG_OBSTACLE, 16'd0);
        ms_clock = 32'($urandom);
        drive_error_run(1060, 1'b1);
        wait_drained();
        write_register(REG_GAIN_P, 16'hFBFF);
        drive_error_run(4, 1'b1);
        wait_drained();
    endtask

    // Random phases: fresh settings each time, then well-formed runs of
    // samples with advancing time, obstacles and near-balanced walls.
    task automatic test_random_phases();
        int          step_max;
        int          delta;
        int          rv;
        logic [9:0]  left;
        logic [9:0]  mid;
        logic [15:0] window;
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            shuffle_idling();
            write_register(REG_GAIN_P, pick_gain());
            write_register(REG_GAIN_I, (phase == 2) ? 16'h8000 : pick_gain());
            write_register(REG_GAIN_D, pick_gain());
            case ($urandom_range(0, 4))
                0:       write_register(REG_SPEED, 16'd0);
                1:       write_register(REG_SPEED, 16'd255);
                default: write_register(REG_SPEED, 16'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_register(REG_OBSTACLE, 16'd1023);
                1:       write_register(REG_OBSTACLE, 16'd0);
                default: write_register(REG_OBSTACLE, 16'($urandom_range(1, 300)));
            endcase
            case ($urandom_range(0, 4))
                0:       window = 16'd0;
                1:       window = 16'hFFFF;
                2:       window = 16'($urandom);
                default: window = 16'($urandom_range(1, 400));
            endcase
            write_register(REG_BOOST, window);
            step_max = int'(window) / 8 + 2;
            if ($urandom_range(0, 1)) ms_clock = 32'($urandom);

            for (int n = 0; n < 20; n++) begin
                ms_clock += $urandom_range(0, step_max);
                if (obstacle_lvl != 0 && $urandom_range(0, 9) < 3)
                    mid = 10'($urandom_range(0, int'(obstacle_lvl) - 1));
                else
                    mid = 10'($urandom);
                left = 10'($urandom);
                if ($urandom_range(0, 1)) begin
                    delta = int'($urandom_range(0, 40)) - 20;
                    rv    = int'(left) + delta;
                    if (rv < 0) rv = 0;
                    if (rv > 1023) rv = 1023;
                end else begin
                    rv = $urandom_range(0, 1023);
                end
                send_sample(left, mid, 10'(rv), ms_clock);
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence: one reset at the start, then each test in turn.
    // ------------------------------------------------------------------
    initial begin
        reset_steering_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_readback();
        test_default_steering();
        test_boost_window();
        test_limits_and_gains();
        test_random_phases();
        test_integral_saturation();
        check_all_registers();
        wait_drained();

        $display("Covered %0d sensor beats, %0d drive beats checked, %0d register writes.",
                 sensor_beats, drives_checked, reg_writes);
        $display("Boost windows opened %0d times; the integral reached its clamp %0d times.",
                 boosts_opened, clamp_hits);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/wfp_pkg.sv
rtl/wfp_drive.sv
rtl/wall_follow_pid_steering_top.sv
rtl/wfp_checker.sv
tb/sv/tb_wall_follow_pid_steering_top.sv
